// ===== design/sdt_pkg.sv =====
// Package for the settle and timeout detector: register indexes, item kinds,
// the configuration bundle and the classified queue entry. No dependencies.
`timescale 1ns / 1ps

package sdt_pkg;

    localparam int CNT_W = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // item kinds, same encoding as the operation field
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_TOLERANCE    = 3'd0;
    localparam logic [2:0] REG_SETTLE_LIMIT = 3'd1;
    localparam logic [2:0] REG_TOTAL_LIMIT  = 3'd2;
    localparam logic [2:0] REG_AXIS_MASK    = 3'd3;
    localparam logic [2:0] REG_TARGET_X     = 3'd4;
    localparam logic [2:0] REG_TARGET_Y     = 3'd5;
    localparam logic [2:0] REG_TARGET_Z     = 3'd6;

    typedef struct packed {
        logic [15:0]        tolerance;
        logic [15:0]        settle_limit;
        logic [15:0]        total_limit;
        logic [2:0]         axis_mask;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       in_tol;   // every enabled axis inside tolerance
    } entry_t;

    // queue read side toward the back end
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } queue_head_t;

endpackage

// ===== design/sdt_front.sv =====
// Front end: decodes the operation and checks the sample against the targets.
// Depends on sdt_pkg.
`timescale 1ns / 1ps

module sdt_front import sdt_pkg::*; (
    input  logic [1:0]         operation,
    input  logic signed [15:0] state_x,
    input  logic signed [15:0] state_y,
    input  logic signed [15:0] state_z,
    input  cfg_t               cfg,
    output entry_t             entry
);

    function automatic logic axis_ok(input logic signed [15:0] s,
                                     input logic signed [15:0] t,
                                     input logic [15:0] tol);
        logic signed [16:0] d;
        logic [16:0]        ad;
        begin
            d  = {s[15], s} - {t[15], t};
            ad = d[16] ? 17'(-d) : 17'(d);
            return ad <= {1'b0, tol};
        end
    endfunction

    logic [2:0] axis_in;

    assign axis_in[0] = axis_ok(state_x, cfg.target_x, cfg.tolerance);
    assign axis_in[1] = axis_ok(state_y, cfg.target_y, cfg.tolerance);
    assign axis_in[2] = axis_ok(state_z, cfg.target_z, cfg.tolerance);

    always_comb begin
        unique case (operation)
            OP_START:  entry.kind = OP_START;
            OP_SAMPLE: entry.kind = OP_SAMPLE;
            OP_TICK:   entry.kind = OP_TICK;
            default:   entry.kind = OP_NONE;
        endcase
        // disabled axes always pass, so an empty mask passes at once
        entry.in_tol = &(axis_in | ~cfg.axis_mask);
    end

endmodule

// ===== design/sdt_queue.sv =====
// Short FIFO of classified entries between front and back end.
// Depends on sdt_pkg.
`timescale 1ns / 1ps

module sdt_queue import sdt_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  entry_t      push_entry,
    output logic        full,
    input  logic        pop,
    output queue_head_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    entry_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == CNT_BITS'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/sdt_back.sv =====
// Back end: owns the reached/finished flags and elapsed counters. Depends on
// sdt_pkg. Applies one entry per cycle unless stalled; holds the result beat.
`timescale 1ns / 1ps

module sdt_back import sdt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  queue_head_t head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] finished, [1] reached, [7:2] zero
);

    logic             reached_reg, reached_next;
    logic             finished_reg, finished_next;
    logic [CNT_W-1:0] since_start_reg, since_start_next;
    logic [CNT_W-1:0] since_reached_reg, since_reached_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [1:0]       m_flags_reg, m_flags_next;
    logic             pop_start;

    assign pop       = head.valid && (!m_tvalid_reg || m_tready);
    assign pop_start = pop && (head.entry.kind == OP_START);

    always_comb begin
        reached_next       = reached_reg;
        finished_next      = finished_reg;
        since_start_next   = since_start_reg;
        since_reached_next = since_reached_reg;
        if (pop) begin
            unique case (head.entry.kind)
                OP_START: begin
                    reached_next       = 1'b0;
                    finished_next      = 1'b0;
                    since_start_next   = '0;
                    since_reached_next = '0;
                end
                OP_TICK: begin
                    if (since_start_reg != CNT_MAX) begin
                        since_start_next = since_start_reg + 1'b1;
                    end
                    if (since_reached_reg != CNT_MAX) begin
                        since_reached_next = since_reached_reg + 1'b1;
                    end
                end
                OP_SAMPLE: begin
                    if (!finished_reg) begin
                        if (!reached_reg && head.entry.in_tol) begin
                            reached_next       = 1'b1;
                            since_reached_next = '0;
                        end
                        if (reached_next && since_reached_next > {1'b0, cfg.settle_limit}) begin
                            finished_next = 1'b1;
                        end else if (since_start_reg > {1'b0, cfg.total_limit}) begin
                            finished_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_flags_next  = m_flags_reg;
        if (pop) begin
            m_tvalid_next = 1'b1;
            m_flags_next  = {reached_next, finished_next};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reached_reg       <= 1'b0;
            finished_reg      <= 1'b0;
            since_start_reg   <= '0;
            since_reached_reg <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            reached_reg       <= reached_next;
            finished_reg      <= finished_next;
            since_start_reg   <= since_start_next;
            since_reached_reg <= since_reached_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_flags_reg <= m_flags_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_flags_reg};

`ifndef NO_ASSERTIONS
    // sticky flags only drop on a start beat
    a_reached_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ($fell(reached_reg) && $past(aresetn)) |-> $past(pop_start))
        else $error("reached dropped without a start");

    a_finished_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ($fell(finished_reg) && $past(aresetn)) |-> $past(pop_start))
        else $error("finished dropped without a start");

    a_total_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(pop_start)) |-> since_start_reg >= $past(since_start_reg))
        else $error("total counter went backward");
`endif

endmodule

// ===== design/settle_and_timeout_detector_top.sv =====
// Top level of the settle and timeout detector: configuration registers,
// front end, entry queue and back end. Depends on sdt_pkg and its submodules.
`timescale 1ns / 1ps

// Usage:
//   s_ channel: one beat per item. s_tuser holds the operation (start, sample,
//   tick); s_tdata holds the three Q8.8 axis values. m_ channel: exactly one
//   beat per input beat, in order, with the finished and reached flags as
//   they stand after that item.
//   cfg channel: register index and 16-bit data, always ready; write only
//   while no item is in flight.
//   Path: an input beat is stored in the queue, then the back end updates
//   flags and counters and registers its result beat in the output register.
//   Throughput: one item per cycle while the queue has room and the receiver
//   takes result beats; the front end compares all three axes in parallel.
//   A stalled receiver holds the result beat in the output register while the
//   queue (QUEUE_DEPTH entries) keeps taking input; s_tready drops only when
//   the queue is full.
//   Reset: flags and counters clear as if a start had been seen, registers
//   return to tolerance 256, settle 100, total 1000, mask 0, targets 0; the
//   queue and output register empty.
module settle_and_timeout_detector_top import sdt_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] state_x, [31:16] state_y, [47:32] state_z
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] finished, [1] reached, [7:2] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t        cfg_reg;
    entry_t      front_entry;
    queue_head_t head;
    logic        queue_full;
    logic        pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tolerance    <= 16'd256;
            cfg_reg.settle_limit <= 16'd100;
            cfg_reg.total_limit  <= 16'd1000;
            cfg_reg.axis_mask    <= 3'd0;
            cfg_reg.target_x     <= '0;
            cfg_reg.target_y     <= '0;
            cfg_reg.target_z     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TOLERANCE:    cfg_reg.tolerance    <= cfg_data;
                REG_SETTLE_LIMIT: cfg_reg.settle_limit <= cfg_data;
                REG_TOTAL_LIMIT:  cfg_reg.total_limit  <= cfg_data;
                REG_AXIS_MASK:    cfg_reg.axis_mask    <= cfg_data[2:0];
                REG_TARGET_X:     cfg_reg.target_x     <= cfg_data;
                REG_TARGET_Y:     cfg_reg.target_y     <= cfg_data;
                REG_TARGET_Z:     cfg_reg.target_z     <= cfg_data;
                default: ;
            endcase
        end
    end

    sdt_front u_front (
        .operation (s_tuser),
        .state_x   (s_tdata[15:0]),
        .state_y   (s_tdata[31:16]),
        .state_z   (s_tdata[47:32]),
        .cfg       (cfg_reg),
        .entry     (front_entry)
    );

    assign s_tready = !queue_full;

    sdt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_tvalid),
        .push_entry (front_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head)
    );

    sdt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
